### rtl/thd_pkg.sv
// ----------------------------------------------------------------------------
// thd_pkg: shared types and constants
// Key modes, item kinds, event codes and the transaction records passed
// between the stages of the tap / hold / double-tap detector.
// ----------------------------------------------------------------------------
package thd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned OpW     = 2;
  localparam int unsigned EvW     = 2;

  localparam logic [CfgW-1:0] HoldTimeoutRst = 16'd250;
  localparam logic [CfgW-1:0] TapWindowRst   = 16'd200;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegHoldTimeout = 1'b0,
    RegTapWindow   = 1'b1
  } cfg_reg_e;

  // Item kinds; code 3 is unused and does nothing
  typedef enum logic [OpW-1:0] {
    OpTick    = 2'd0,
    OpPress   = 2'd1,
    OpRelease = 2'd2
  } op_e;

  // Key modes; codes 5..7 are unreachable and hold until reset
  typedef enum logic [2:0] {
    ModeIdle     = 3'd0,
    ModePressed  = 3'd1,
    ModeFirstUp  = 3'd2,
    ModeHold     = 3'd3,
    ModeDouble   = 3'd4
  } mode_e;

  // Event codes
  typedef enum logic [EvW-1:0] {
    EvRelease   = 2'd0,
    EvTap       = 2'd1,
    EvHold      = 2'd2,
    EvDoubleTap = 2'd3
  } event_e;

  // One input item as held in the input register
  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic             is_overlay_key;
    logic [TimeW-1:0] now_ms;
  } item_t;

  // Result of one step
  typedef struct packed {
    logic             emit;
    logic [EvW-1:0]   event_code;
  } result_t;

endpackage

### rtl/thd_item_if.sv
// ----------------------------------------------------------------------------
// thd_item_if: input item channel
// Valid/ready channel carrying one key or tick item.
// ----------------------------------------------------------------------------
interface thd_item_if;
  logic                        valid;
  logic                        ready;
  logic [thd_pkg::OpW-1:0]     opcode;
  logic                        is_overlay_key;
  logic [thd_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, output opcode, output is_overlay_key, output now_ms,
                  input ready);
  modport sink   (input valid, input opcode, input is_overlay_key, input now_ms,
                  output ready);
endinterface

### rtl/thd_event_if.sv
// ----------------------------------------------------------------------------
// thd_event_if: result event channel
// Valid/ready channel carrying one event code.
// ----------------------------------------------------------------------------
interface thd_event_if;
  logic                      valid;
  logic                      ready;
  logic [thd_pkg::EvW-1:0]   event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

### rtl/thd_cfg_if.sv
// ----------------------------------------------------------------------------
// thd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface thd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [thd_pkg::CfgIdxW-1:0]  index;
  logic [thd_pkg::CfgW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/thd_in_stage.sv
// ----------------------------------------------------------------------------
// thd_in_stage: input register
// Captures one item per transaction and hands it to the core when the
// output side can take the step's result.
// ----------------------------------------------------------------------------
module thd_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  thd_item_if.sink       in_i,
  input  logic           out_free_i,
  output logic           fire_o,
  output thd_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  thd_pkg::item_t item_q;

  // The held item steps when the output register can be loaded
  assign fire_o   = valid_q && out_free_i;
  assign in_i.ready = !valid_q || out_free_i;
  assign item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.opcode         <= in_i.opcode;
      item_q.is_overlay_key <= in_i.is_overlay_key;
      item_q.now_ms         <= in_i.now_ms;
    end
  end

endmodule

### rtl/thd_core.sv
// ----------------------------------------------------------------------------
// thd_core: key mode machine
// Holds the configuration, key mode and timestamps; one step per fired item
// with a wrapping subtract and compare for each timeout.
// ----------------------------------------------------------------------------
module thd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  thd_cfg_if.sink          cfg_i,
  input  logic             fire_i,
  input  thd_pkg::item_t   item_i,
  output thd_pkg::result_t result_o
);

  logic [thd_pkg::CfgW-1:0]  hold_timeout_q, tap_window_q;
  thd_pkg::mode_e            mode_q, mode_d;
  logic [thd_pkg::TimeW-1:0] press_time_q, release_time_q;
  logic [thd_pkg::TimeW-1:0] press_age, release_age;
  logic                      hold_expired, tap_expired;
  logic                      is_tick, is_press, is_release;
  logic                      load_press, load_release;

  // Decode the item
  assign is_tick    = item_i.opcode == thd_pkg::OpTick;
  assign is_press   = item_i.is_overlay_key && (item_i.opcode == thd_pkg::OpPress);
  assign is_release = item_i.is_overlay_key && (item_i.opcode == thd_pkg::OpRelease);

  // Wrapping ages against the timeouts
  assign press_age    = item_i.now_ms - press_time_q;
  assign release_age  = item_i.now_ms - release_time_q;
  assign hold_expired = press_age > {{(thd_pkg::TimeW-thd_pkg::CfgW){1'b0}}, hold_timeout_q};
  assign tap_expired  = release_age > {{(thd_pkg::TimeW-thd_pkg::CfgW){1'b0}}, tap_window_q};

  // Configuration writes, always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_timeout_q <= thd_pkg::HoldTimeoutRst;
      tap_window_q   <= thd_pkg::TapWindowRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        thd_pkg::RegHoldTimeout: hold_timeout_q <= cfg_i.data;
        thd_pkg::RegTapWindow:   tap_window_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Next mode
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      thd_pkg::ModeIdle: begin
        if (is_press) mode_d = thd_pkg::ModePressed;
      end
      thd_pkg::ModePressed: begin
        if (is_tick && hold_expired) mode_d = thd_pkg::ModeHold;
        else if (is_release)         mode_d = thd_pkg::ModeFirstUp;
      end
      thd_pkg::ModeFirstUp: begin
        if (is_tick && tap_expired) mode_d = thd_pkg::ModeIdle;
        else if (is_press)          mode_d = thd_pkg::ModeDouble;
      end
      thd_pkg::ModeHold, thd_pkg::ModeDouble: begin
        if (is_release) mode_d = thd_pkg::ModeIdle;
      end
      default: mode_d = mode_q;
    endcase
  end

  // Outputs of the step: event and timestamp loads
  always_comb begin
    result_o.emit       = 1'b0;
    result_o.event_code = thd_pkg::EvRelease;
    load_press          = 1'b0;
    load_release        = 1'b0;
    unique case (mode_q)
      thd_pkg::ModeIdle: begin
        load_press = is_press;
      end
      thd_pkg::ModePressed: begin
        if (is_tick && hold_expired) begin
          result_o.emit       = 1'b1;
          result_o.event_code = thd_pkg::EvHold;
        end else begin
          load_release = is_release;
        end
      end
      thd_pkg::ModeFirstUp: begin
        if (is_tick && tap_expired) begin
          result_o.emit       = 1'b1;
          result_o.event_code = thd_pkg::EvTap;
        end else if (is_press) begin
          result_o.emit       = 1'b1;
          result_o.event_code = thd_pkg::EvDoubleTap;
        end
      end
      thd_pkg::ModeHold, thd_pkg::ModeDouble: begin
        if (is_release) begin
          result_o.emit       = 1'b1;
          result_o.event_code = thd_pkg::EvRelease;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= thd_pkg::ModeIdle;
      press_time_q   <= '0;
      release_time_q <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      if (load_press)   press_time_q   <= item_i.now_ms;
      if (load_release) release_time_q <= item_i.now_ms;
    end
  end

  // A hold event always leaves the key in hold mode
  a_hold_enters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.emit && (result_o.event_code == thd_pkg::EvHold)
    |=> mode_q == thd_pkg::ModeHold)
    else $error("hold event without entering hold mode");

  // A double tap only comes out of first-up mode
  a_double_from_first_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.emit && (result_o.event_code == thd_pkg::EvDoubleTap)
    |-> mode_q == thd_pkg::ModeFirstUp)
    else $error("double tap outside first-up mode");

  // The press time moves only on a press taken in idle mode
  a_press_time_guarded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && is_press && (mode_q == thd_pkg::ModeIdle)) |=> $stable(press_time_q))
    else $error("press time changed outside an idle press");

  // The release time moves only on a release taken in pressed mode
  a_release_time_guarded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && is_release && (mode_q == thd_pkg::ModePressed) && !is_tick)
    |=> $stable(release_time_q))
    else $error("release time changed outside a pressed release");

endmodule

### rtl/thd_out_stage.sv
// ----------------------------------------------------------------------------
// thd_out_stage: result register
// Holds one event until its transaction completes; reports when it can be
// loaded so the input side keeps moving.
// ----------------------------------------------------------------------------
module thd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  thd_event_if.source      out_o,
  input  logic             fire_i,
  input  thd_pkg::result_t result_i,
  output logic             free_o
);

  logic                   valid_q, valid_d;
  logic [thd_pkg::EvW-1:0] code_q;

  assign free_o           = !valid_q || out_o.ready;
  assign out_o.valid      = valid_q;
  assign out_o.event_code = code_q;

  // Load on a step, otherwise drain on a completed transaction
  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = result_i.emit;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && result_i.emit) begin
      code_q <= result_i.event_code;
    end
  end

endmodule

### rtl/tap_hold_double_tap_detector.sv
// Flow: an accepted item is held in the input register until the output register
//   can be loaded; its event, if any, is then offered on the output channel.
// Throughput: one item per cycle; a held result stalls the input only while
//   the output channel is not ready.
// Reset (rst_ni low, asynchronous): mode idle, timestamps zero, hold timeout
//   250 ms, tap window 200 ms, both channel registers empty.
// ----------------------------------------------------------------------------
// tap_hold_double_tap_detector: top level
// Classifies one special key as tap, hold, double tap or release from press,
// release and timer tick items.
// ----------------------------------------------------------------------------
module tap_hold_double_tap_detector (
  input  logic         clk_i,
  input  logic         rst_ni,
  thd_cfg_if.sink      cfg_i,
  thd_item_if.sink     in_i,
  thd_event_if.source  out_o
);

  logic             fire;
  logic             out_free;
  thd_pkg::item_t   item;
  thd_pkg::result_t result;

  thd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .fire_o     (fire),
    .item_o     (item)
  );

  thd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  thd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .out_o    (out_o),
    .fire_i   (fire),
    .result_i (result),
    .free_o   (out_free)
  );

endmodule

### sim/tb_tap_hold_double_tap_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tap_hold_double_tap_detector: self-checking testbench
// Drives press, release and tick transactions into the detector under
// several timeout settings. A scoreboard tracks the key mode and timestamps
// and predicts each event code in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_tap_hold_double_tap_detector;
  import thd_pkg::*;

  localparam logic [OpW-1:0] OpUnused  = 2'd3;
  localparam int unsigned    QuietMax  = 5000;
  localparam int unsigned    NumPhases = 7;
  localparam int unsigned    PhaseLen  = 200;

  // Tracks the key mode and predicts the event stream
  class key_event_tracker;
    mode_e             mode;
    logic [TimeW-1:0]  press_ms;
    logic [TimeW-1:0]  release_ms;
    logic [CfgW-1:0]   hold_limit;
    logic [CfgW-1:0]   tap_limit;
    event_e            pending_events[$];
    int unsigned       errors;
    int unsigned       items_seen;
    int unsigned       events_seen;
    int unsigned       reg_writes;

    function new();
      mode        = ModeIdle;
      press_ms    = '0;
      release_ms  = '0;
      hold_limit  = HoldTimeoutRst;
      tap_limit   = TapWindowRst;
      errors      = 0;
      items_seen  = 0;
      events_seen = 0;
      reg_writes  = 0;
    endfunction

    function void apply_setting(cfg_reg_e idx, logic [CfgW-1:0] val);
      reg_writes++;
      case (idx)
        RegHoldTimeout: hold_limit = val;
        RegTapWindow:   tap_limit  = val;
        default: ;
      endcase
    endfunction

    // Accepted input transaction: advance the mode, queue any event
    function void note_item(logic [OpW-1:0] op, logic ovl, logic [TimeW-1:0] now);
      logic [TimeW-1:0] elapsed;
      items_seen++;
      case (op)
        OpTick: begin
          if (mode == ModePressed) begin
            elapsed = now - press_ms;
            if (elapsed > TimeW'(hold_limit)) begin
              mode = ModeHold;
              pending_events.push_back(EvHold);
            end
          end else if (mode == ModeFirstUp) begin
            elapsed = now - release_ms;
            if (elapsed > TimeW'(tap_limit)) begin
              mode = ModeIdle;
              pending_events.push_back(EvTap);
            end
          end
        end
        OpPress: begin
          if (ovl && mode == ModeIdle) begin
            mode     = ModePressed;
            press_ms = now;
          end else if (ovl && mode == ModeFirstUp) begin
            mode = ModeDouble;
            pending_events.push_back(EvDoubleTap);
          end
        end
        OpRelease: begin
          if (ovl && mode == ModePressed) begin
            mode       = ModeFirstUp;
            release_ms = now;
          end else if (ovl && (mode == ModeHold || mode == ModeDouble)) begin
            mode = ModeIdle;
            pending_events.push_back(EvRelease);
          end
        end
        default: ;
      endcase
    endfunction

    // Accepted output transaction: compare with the oldest prediction
    function void check_event(logic [EvW-1:0] code);
      event_e want;
      events_seen++;
      if (pending_events.size() == 0) begin
        errors++;
        $error("event_code: no event expected, actual %0d", code);
        return;
      end
      want = pending_events.pop_front();
      if (code !== want) begin
        errors++;
        $error("event_code mismatch: expected %0d, actual %0d", want, code);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  thd_cfg_if   cfg_if ();
  thd_item_if  item_if ();
  thd_event_if ev_if ();

  key_event_tracker tracker = new();

  logic [TimeW-1:0] clock_ms;
  logic [CfgW-1:0]  cur_hold;
  logic [CfgW-1:0]  cur_tap;
  int unsigned      useful_items;
  int unsigned      send_quiet;
  int unsigned      quiet_cycles;
  bit               pressure_done;

  tap_hold_double_tap_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (item_if),
    .out_o  (ev_if)
  );

  always #10 clk_i = ~clk_i;

  // Monitor: every accepted transaction goes to the scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (ev_if.valid && ev_if.ready) tracker.check_event(ev_if.event_code);
      if (item_if.valid && item_if.ready)
        tracker.note_item(item_if.opcode, item_if.is_overlay_key, item_if.now_ms);
      if (cfg_if.valid && cfg_if.ready)
        tracker.apply_setting(cfg_reg_e'(cfg_if.index), cfg_if.data);
      if ((ev_if.valid && ev_if.ready) || (item_if.valid && item_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: no transaction for too long means the block hung
  initial begin : watchdog
    while (quiet_cycles < QuietMax) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // Event sink: random back-pressure plus one long hold-off
  initial begin : event_sink
    int unsigned stall;
    int unsigned run;
    int unsigned r;
    ev_if.ready   = 1'b0;
    pressure_done = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!pressure_done && tracker.items_seen >= 300) begin
        ev_if.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        pressure_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 50)      stall = 0;
      else if (r < 82) stall = $urandom_range(1, 3);
      else if (r < 96) stall = $urandom_range(4, 15);
      else             stall = $urandom_range(30, 80);
      if (stall != 0) begin
        ev_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ev_if.ready <= 1'b1;
      run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(60, 300);
      repeat (run) @(posedge clk_i);
    end
  end

  // One input transaction with a random gap ahead of it
  task automatic send_item(input logic [OpW-1:0] op, input logic ovl,
                           input logic [TimeW-1:0] now);
    int unsigned gap;
    int unsigned r;
    if (send_quiet != 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_quiet = $urandom_range(30, 150);
        gap = 0;
      end else if (r < 55) gap = 0;
      else if (r < 85)     gap = $urandom_range(1, 3);
      else if (r < 97)     gap = $urandom_range(4, 12);
      else                 gap = $urandom_range(20, 60);
    end
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid          <= 1'b1;
    item_if.opcode         <= op;
    item_if.is_overlay_key <= ovl;
    item_if.now_ms         <= now;
    do @(posedge clk_i); while (!item_if.ready);
    if (op != OpUnused && (op == OpTick || ovl)) useful_items++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain: all events back, then wait for items still in flight
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (tracker.pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Delay that does not exceed a timeout (often exactly on it)
  function automatic logic [TimeW-1:0] early_ms(input logic [CfgW-1:0] limit);
    if ($urandom_range(0, 3) == 0) return TimeW'(limit);
    return $urandom_range(0, limit);
  endfunction

  // Delay that exceeds a timeout (often by just one)
  function automatic logic [TimeW-1:0] late_ms(input logic [CfgW-1:0] limit);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return TimeW'(limit) + 1;
    if (r < 9) return TimeW'(limit) + 1 + $urandom_range(0, 3000);
    return TimeW'(limit) + 1 + $urandom_range(0, 32'h7FFF_FFFF);
  endfunction

  // Sometimes slip in a transaction the block must ignore
  task automatic other_noise();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20)      send_item(2'($urandom_range(1, 2)), 1'b0, $urandom());
    else if (r < 30) send_item(OpUnused, 1'($urandom_range(0, 1)), $urandom());
  endtask

  // Directed: boundaries, wrap, ignored items, every event
  task automatic directed_items();
    send_item(OpPress,   1'b1, 32'h0000_0000);
    send_item(OpTick,    1'b0, 32'd250);          // exactly on the hold timeout
    send_item(OpTick,    1'b1, 32'd251);          // hold
    send_item(OpPress,   1'b1, 32'd300);          // press while held
    send_item(OpRelease, 1'b0, 32'd301);          // other key
    send_item(OpRelease, 1'b1, 32'd302);          // release
    send_item(OpRelease, 1'b1, 32'd303);          // release while idle
    send_item(OpUnused,  1'b1, 32'hFFFF_FFFF);
    send_item(OpPress,   1'b1, 32'hFFFF_FF80);
    send_item(OpRelease, 1'b1, 32'hFFFF_FFF0);
    send_item(OpTick,    1'b0, 32'h0000_00B8);    // window reached across the wrap
    send_item(OpTick,    1'b1, 32'h0000_00B9);    // tap
    send_item(OpPress,   1'b1, 32'h0000_1000);
    send_item(OpPress,   1'b1, 32'h0000_1001);    // second press while down
    send_item(OpRelease, 1'b1, 32'h0000_1002);
    send_item(OpPress,   1'b0, 32'h0000_1003);    // other key
    send_item(OpPress,   1'b1, 32'h0000_1004);    // double tap
    send_item(OpTick,    1'b1, 32'hFFFF_FFFF);    // tick has no effect in double
    send_item(OpRelease, 1'b1, 32'h0000_2000);
    send_item(OpUnused,  1'b0, 32'h0000_0000);
    send_item(OpPress,   1'b1, 32'h7FFF_FFFF);
    send_item(OpTick,    1'b0, 32'h8000_00FA);
    send_item(OpRelease, 1'b1, 32'h8000_00FB);
  endtask

  // Random phase: mostly complete gestures, some broken sequences
  task automatic run_phase(input int unsigned count);
    int unsigned target;
    int unsigned r;
    int unsigned k;
    target = useful_items + count;
    while (useful_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 27) begin
        // tap
        send_item(OpPress, 1'b1, clock_ms);
        other_noise();
        clock_ms += early_ms(cur_hold);
        send_item(OpRelease, 1'b1, clock_ms);
        if ($urandom_range(0, 1))
          send_item(OpTick, 1'($urandom_range(0, 1)), clock_ms + early_ms(cur_tap));
        other_noise();
        clock_ms += late_ms(cur_tap);
        send_item(OpTick, 1'($urandom_range(0, 1)), clock_ms);
      end else if (r < 52) begin
        // hold then release
        send_item(OpPress, 1'b1, clock_ms);
        if ($urandom_range(0, 1))
          send_item(OpTick, 1'($urandom_range(0, 1)), clock_ms + early_ms(cur_hold));
        clock_ms += late_ms(cur_hold);
        send_item(OpTick, 1'($urandom_range(0, 1)), clock_ms);
        other_noise();
        if ($urandom_range(0, 3) == 0) send_item(OpPress, 1'b1, clock_ms);
        clock_ms += $urandom_range(0, 5000);
        send_item(OpRelease, 1'b1, clock_ms);
      end else if (r < 78) begin
        // double tap then release
        send_item(OpPress, 1'b1, clock_ms);
        clock_ms += early_ms(cur_hold);
        send_item(OpRelease, 1'b1, clock_ms);
        other_noise();
        clock_ms += early_ms(cur_tap);
        send_item(OpPress, 1'b1, clock_ms);
        if ($urandom_range(0, 1))
          send_item(OpTick, 1'($urandom_range(0, 1)), clock_ms + late_ms(cur_hold));
        clock_ms += $urandom_range(0, 3000);
        send_item(OpRelease, 1'b1, clock_ms);
      end else begin
        // broken sequence, then a far tick and a release to get back to idle
        k = $urandom_range(1, 6);
        repeat (k) begin
          clock_ms += $urandom_range(0, 2 * cur_hold + 2);
          send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), clock_ms);
        end
        clock_ms += 32'h0001_0000 + $urandom_range(0, 100);
        send_item(OpTick, 1'($urandom_range(0, 1)), clock_ms);
        send_item(OpRelease, 1'b1, clock_ms);
      end
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
    end
  endtask

  // Main sequence
  initial begin : stimulus
    logic [CfgW-1:0] hold_set [NumPhases];
    logic [CfgW-1:0] tap_set  [NumPhases];
    hold_set = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd0, 16'd250};
    tap_set  = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd200};
    hold_set[4] = CfgW'($urandom_range(0, 1000));
    tap_set[4]  = CfgW'($urandom_range(0, 1000));
    hold_set[5] = CfgW'($urandom_range(0, 16'hFFFF));
    tap_set[5]  = CfgW'($urandom_range(0, 16'hFFFF));

    item_if.valid          = 1'b0;
    item_if.opcode         = OpTick;
    item_if.is_overlay_key = 1'b0;
    item_if.now_ms         = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = RegHoldTimeout;
    cfg_if.data            = '0;
    useful_items           = 0;
    send_quiet             = 0;
    cur_hold               = HoldTimeoutRst;
    cur_tap                = TapWindowRst;
    rst_ni                 = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(RegHoldTimeout, hold_set[p]);
      write_reg(RegTapWindow, tap_set[p]);
      cur_hold = hold_set[p];
      cur_tap  = tap_set[p];
      clock_ms = $urandom();
      run_phase(PhaseLen);
      wait_idle();
    end

    $display("Covered %0d input items and %0d events under %0d timeout settings",
             tracker.items_seen, tracker.events_seen, NumPhases + 1);
    $display("(%0d register writes, incl. zero and full-scale timeouts, with wrap)",
             tracker.reg_writes);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/thd_pkg.sv
rtl/thd_item_if.sv
rtl/thd_event_if.sv
rtl/thd_cfg_if.sv
rtl/thd_in_stage.sv
rtl/thd_core.sv
rtl/thd_out_stage.sv
rtl/tap_hold_double_tap_detector.sv
sim/tb_tap_hold_double_tap_detector.sv
